// File: rtl/core/sip_pkg.sv
// Package for the segment intersection parameter unit.
// Holds the fixed field widths and the default parameter values.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package sip_pkg;

    // Widths of the transaction fields.
    localparam int COORD_W = 16;
    localparam int PARAM_W = 32;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

endpackage

`default_nettype wire

// File: rtl/core/sip_in_if.sv
// Request channel of the segment intersection parameter unit.
// Carries the four segment endpoints with a valid/ready handshake.
// Depends on sip_pkg.
`default_nettype none

interface sip_in_if;
    logic                        valid;
    logic                        ready;
    logic [sip_pkg::COORD_W-1:0] p1_x;
    logic [sip_pkg::COORD_W-1:0] p1_y;
    logic [sip_pkg::COORD_W-1:0] p2_x;
    logic [sip_pkg::COORD_W-1:0] p2_y;
    logic [sip_pkg::COORD_W-1:0] q1_x;
    logic [sip_pkg::COORD_W-1:0] q1_y;
    logic [sip_pkg::COORD_W-1:0] q2_x;
    logic [sip_pkg::COORD_W-1:0] q2_y;

    modport source (output valid, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y,
                    input ready);
    modport sink (input valid, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/sip_out_if.sv
// Response channel of the segment intersection parameter unit.
// Carries the two intersection parameters and the hit flag.
// Depends on sip_pkg.
`default_nettype none

interface sip_out_if;
    logic                        valid;
    logic                        ready;
    logic [sip_pkg::PARAM_W-1:0] param_a;
    logic [sip_pkg::PARAM_W-1:0] param_b;
    logic                        lines_meet;

    modport source (output valid, param_a, param_b, lines_meet, input ready);
    modport sink (input valid, param_a, param_b, lines_meet, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sip_front.sv
// Front end of the segment intersection parameter unit: differences,
// cross products and signed magnitudes over three register stages.
// Depends on sip_pkg.
`default_nettype none

module sip_front #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int MW         = 2 * COORD_BITS + 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [sip_pkg::COORD_W-1:0] p1_x,
    input  wire logic [sip_pkg::COORD_W-1:0] p1_y,
    input  wire logic [sip_pkg::COORD_W-1:0] p2_x,
    input  wire logic [sip_pkg::COORD_W-1:0] p2_y,
    input  wire logic [sip_pkg::COORD_W-1:0] q1_x,
    input  wire logic [sip_pkg::COORD_W-1:0] q1_y,
    input  wire logic [sip_pkg::COORD_W-1:0] q2_x,
    input  wire logic [sip_pkg::COORD_W-1:0] q2_y,
    output logic                             out_valid,
    output logic [MW-1:0]                    num_a_mag,
    output logic [MW-1:0]                    num_b_mag,
    output logic [MW-1:0]                    den_mag,
    output logic                             neg_a,
    output logic                             neg_b,
    output logic                             meet
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] c_p1x, c_p1y, c_p2x, c_p2y, c_q1x, c_q1y, c_q2x, c_q2y;
    logic signed [DW-1:0] dpx_reg, dpy_reg, dqx_reg, dqy_reg, rx_reg, ry_reg;
    logic signed [PW-1:0] m_reg [0:5];
    logic signed [PW-1:0] m_next [0:5];
    logic signed [PW-1:0] den, num_a, num_b;
    logic                 va_reg, vb_reg, vc_reg;
    logic [MW-1:0]        num_a_mag_reg, num_b_mag_reg, den_mag_reg;
    logic                 neg_a_reg, neg_b_reg, meet_reg;

    // Coordinates are the sign-extended low COORD_BITS bits of each field.
    assign c_p1x = DW'(signed'(p1_x[COORD_BITS-1:0]));
    assign c_p1y = DW'(signed'(p1_y[COORD_BITS-1:0]));
    assign c_p2x = DW'(signed'(p2_x[COORD_BITS-1:0]));
    assign c_p2y = DW'(signed'(p2_y[COORD_BITS-1:0]));
    assign c_q1x = DW'(signed'(q1_x[COORD_BITS-1:0]));
    assign c_q1y = DW'(signed'(q1_y[COORD_BITS-1:0]));
    assign c_q2x = DW'(signed'(q2_x[COORD_BITS-1:0]));
    assign c_q2y = DW'(signed'(q2_y[COORD_BITS-1:0]));

    // Six cross-product terms, one multiplier each.
    always_comb
    begin
        m_next[0] = PW'(dpx_reg) * PW'(dqy_reg);
        m_next[1] = PW'(dpy_reg) * PW'(dqx_reg);
        m_next[2] = PW'(ry_reg) * PW'(dqx_reg);
        m_next[3] = PW'(rx_reg) * PW'(dqy_reg);
        m_next[4] = PW'(ry_reg) * PW'(dpx_reg);
        m_next[5] = PW'(rx_reg) * PW'(dpy_reg);
    end

    // Denominator and numerators; the sums never reach the top bit in magnitude.
    assign den   = m_reg[0] - m_reg[1];
    assign num_a = m_reg[2] - m_reg[3];
    assign num_b = m_reg[4] - m_reg[5];

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dpx_reg <= c_p2x - c_p1x;
            dpy_reg <= c_p2y - c_p1y;
            dqx_reg <= c_q2x - c_q1x;
            dqy_reg <= c_q2y - c_q1y;
            rx_reg  <= c_p1x - c_q1x;
            ry_reg  <= c_p1y - c_q1y;
            for (int i = 0; i < 6; i++)
            begin
                m_reg[i] <= m_next[i];
            end
            num_a_mag_reg <= num_a[PW-1] ? MW'(-num_a) : MW'(num_a);
            num_b_mag_reg <= num_b[PW-1] ? MW'(-num_b) : MW'(num_b);
            den_mag_reg   <= den[PW-1] ? MW'(-den) : MW'(den);
            neg_a_reg     <= num_a[PW-1] ^ den[PW-1];
            neg_b_reg     <= num_b[PW-1] ^ den[PW-1];
            meet_reg      <= (den != '0);
        end
    end

    assign out_valid = vc_reg;
    assign num_a_mag = num_a_mag_reg;
    assign num_b_mag = num_b_mag_reg;
    assign den_mag   = den_mag_reg;
    assign neg_a     = neg_a_reg;
    assign neg_b     = neg_b_reg;
    assign meet      = meet_reg;

endmodule

`default_nettype wire

// File: rtl/core/sip_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit for
// both parameters and hands the partial state to the next cell.
// Depends on sip_pkg.
`default_nettype none

module sip_div_cell #(
    parameter int MW = 2 * sip_pkg::COORD_BITS_DEF + 1,
    parameter int NW = MW + sip_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        valid_i,
    input  wire logic                        meet_i,
    input  wire logic [MW-1:0]               d_i,
    input  wire logic [NW-1:0]               n_i [2],
    input  wire logic [MW-1:0]               r_i [2],
    input  wire logic [sip_pkg::PARAM_W-1:0] q_i [2],
    input  wire logic                        ovf_i [2],
    input  wire logic                        neg_i [2],
    output logic                             valid_o,
    output logic                             meet_o,
    output logic [MW-1:0]                    d_o,
    output logic [NW-1:0]                    n_o [2],
    output logic [MW-1:0]                    r_o [2],
    output logic [sip_pkg::PARAM_W-1:0]      q_o [2],
    output logic                             ovf_o [2],
    output logic                             neg_o [2]
);

    localparam int QW = sip_pkg::PARAM_W;

    logic          valid_reg, meet_reg;
    logic [MW-1:0] d_reg;
    logic [NW-1:0] n_reg [2];
    logic [MW-1:0] r_reg [2];
    logic [QW-1:0] q_reg [2];
    logic          ovf_reg [2];
    logic          neg_reg [2];
    logic [MW:0]   rem2 [2];
    logic [MW:0]   diff [2];
    logic          take [2];

    // Trial subtraction of the divisor from the shifted remainder, per lane.
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rem2[k] = {r_i[k], n_i[k][NW-1]};
            diff[k] = rem2[k] - {1'b0, d_i};
            take[k] = (rem2[k] >= {1'b0, d_i});
        end
    end

    // Valid bit of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    // Partial quotient, remainder and remaining dividend bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meet_reg <= meet_i;
            d_reg    <= d_i;
            for (int k = 0; k < 2; k++)
            begin
                n_reg[k]   <= n_i[k] << 1;
                r_reg[k]   <= take[k] ? diff[k][MW-1:0] : rem2[k][MW-1:0];
                q_reg[k]   <= {q_i[k][QW-2:0], take[k]};
                ovf_reg[k] <= ovf_i[k] | q_i[k][QW-1];
                neg_reg[k] <= neg_i[k];
            end
        end
    end

    assign valid_o = valid_reg;
    assign meet_o  = meet_reg;
    assign d_o     = d_reg;
    assign n_o     = n_reg;
    assign r_o     = r_reg;
    assign q_o     = q_reg;
    assign ovf_o   = ovf_reg;
    assign neg_o   = neg_reg;

endmodule

`default_nettype wire

// File: rtl/core/segment_intersection_params_unit.sv
// Segment intersection parameter unit: a = (ry*dQx - rx*dQy)/denom and
// b = (ry*dPx - rx*dPy)/denom in signed Q15.16, saturated, zero when parallel.
// Pipeline: three front stages, one divider cell per dividend bit, output register.
// Throughput: one transaction per cycle; the whole chain holds while a result waits.
// Reset clears the valid bits of every stage; data registers are not reset.
`default_nettype none

module segment_intersection_params_unit #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sip_in_if.sink    req,
    sip_out_if.source rsp
);

    localparam int MW = 2 * COORD_BITS + 1;
    localparam int NW = MW + FRAC_BITS;
    localparam int QW = sip_pkg::PARAM_W;
    localparam logic [QW-1:0] MAX_POS = {1'b0, {(QW - 1){1'b1}}};
    localparam logic [QW-1:0] MAX_NEG = {1'b1, {(QW - 1){1'b0}}};

    logic          en;
    logic          f_valid, f_neg_a, f_neg_b, f_meet;
    logic [MW-1:0] f_num_a, f_num_b, f_den;

    logic          c_valid [0:NW];
    logic          c_meet  [0:NW];
    logic [MW-1:0] c_d     [0:NW];
    logic [NW-1:0] c_n     [0:NW][2];
    logic [MW-1:0] c_r     [0:NW][2];
    logic [QW-1:0] c_q     [0:NW][2];
    logic          c_ovf   [0:NW][2];
    logic          c_neg   [0:NW][2];

    logic          out_valid_reg;
    logic [QW-1:0] param_a_reg, param_b_reg;
    logic          meet_out_reg;
    logic [QW-1:0] sat_val [2];

    // The chain moves whenever the output register is free or being emptied.
    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    sip_front #(
        .COORD_BITS (COORD_BITS),
        .MW         (MW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .p1_x      (req.p1_x),
        .p1_y      (req.p1_y),
        .p2_x      (req.p2_x),
        .p2_y      (req.p2_y),
        .q1_x      (req.q1_x),
        .q1_y      (req.q1_y),
        .q2_x      (req.q2_x),
        .q2_y      (req.q2_y),
        .out_valid (f_valid),
        .num_a_mag (f_num_a),
        .num_b_mag (f_num_b),
        .den_mag   (f_den),
        .neg_a     (f_neg_a),
        .neg_b     (f_neg_b),
        .meet      (f_meet)
    );

    // Head of the divider chain: numerators scaled by the fraction bits.
    assign c_valid[0]  = f_valid;
    assign c_meet[0]   = f_meet;
    assign c_d[0]      = f_den;
    assign c_n[0][0]   = NW'(f_num_a) << FRAC_BITS;
    assign c_n[0][1]   = NW'(f_num_b) << FRAC_BITS;
    assign c_r[0][0]   = '0;
    assign c_r[0][1]   = '0;
    assign c_q[0][0]   = '0;
    assign c_q[0][1]   = '0;
    assign c_ovf[0][0] = 1'b0;
    assign c_ovf[0][1] = 1'b0;
    assign c_neg[0][0] = f_neg_a;
    assign c_neg[0][1] = f_neg_b;

    // One cell per dividend bit.
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        sip_div_cell #(
            .MW (MW),
            .NW (NW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid_i (c_valid[i]),
            .meet_i  (c_meet[i]),
            .d_i     (c_d[i]),
            .n_i     (c_n[i]),
            .r_i     (c_r[i]),
            .q_i     (c_q[i]),
            .ovf_i   (c_ovf[i]),
            .neg_i   (c_neg[i]),
            .valid_o (c_valid[i+1]),
            .meet_o  (c_meet[i+1]),
            .d_o     (c_d[i+1]),
            .n_o     (c_n[i+1]),
            .r_o     (c_r[i+1]),
            .q_o     (c_q[i+1]),
            .ovf_o   (c_ovf[i+1]),
            .neg_o   (c_neg[i+1])
        );
    end

    // Sign and saturation of the finished quotients; zero for parallel lines.
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (!c_meet[NW])
            begin
                sat_val[k] = '0;
            end
            else if (c_neg[NW][k])
            begin
                if (c_ovf[NW][k] || (c_q[NW][k][QW-1] && (c_q[NW][k][QW-2:0] != '0)))
                begin
                    sat_val[k] = MAX_NEG;
                end
                else
                begin
                    sat_val[k] = -c_q[NW][k];
                end
            end
            else if (c_ovf[NW][k] || c_q[NW][k][QW-1])
            begin
                sat_val[k] = MAX_POS;
            end
            else
            begin
                sat_val[k] = c_q[NW][k];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_valid[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            param_a_reg  <= sat_val[0];
            param_b_reg  <= sat_val[1];
            meet_out_reg <= c_meet[NW];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.param_a    = param_a_reg;
    assign rsp.param_b    = param_b_reg;
    assign rsp.lines_meet = meet_out_reg;

    // Parallel lines always give zero parameters.
    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.lines_meet |-> rsp.param_a == '0 && rsp.param_b == '0)
        else $error("parallel result with nonzero parameters");

    // No new transaction enters while a finished result is held back.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("input accepted while output stalled");

    // A meeting pair always enters the divider with a nonzero divisor.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && f_meet |-> f_den != '0)
        else $error("zero divisor flagged as meeting");

    // A result held by the last cell while the chain moves is taken into the output register.
    a_chain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        en && c_valid[NW] |=> rsp.valid)
        else $error("result lost between chain and output register");

endmodule

`default_nettype wire

// File: test/segment_intersection_params_unit_tb.sv
// Self-checking testbench for the segment intersection parameter unit.
// Drives segment pairs through the request channel and checks each response
// against a predictor of the exact fixed-point quotients.
// Depends on sip_pkg and the interfaces.
`timescale 1ns / 1ps

module segment_intersection_params_unit_tb;

    localparam int LATENCY  = 2 * sip_pkg::COORD_BITS_DEF + sip_pkg::FRAC_BITS_DEF + 5;
    localparam int WDOG_MAX = 20000;
    localparam int N_RANDOM = 800;

    typedef logic [sip_pkg::COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [sip_pkg::PARAM_W-1:0] param_a;
        logic [sip_pkg::PARAM_W-1:0] param_b;
        logic                        lines_meet;
    } isect_t;

    typedef struct {
        coord_t c[8];
        logic   has_exp;
        isect_t exp;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sip_in_if  req ();
    sip_out_if rsp ();

    segment_intersection_params_unit dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always #5 clk = ~clk;

    isect_t expected_q[$];
    int     n_errors = 0;
    int     idle_cycles = 0;
    int     src_idle_pct = 15;
    int     snk_idle_pct = 74;

    // Exact num * 2^16 / den, truncated toward zero, saturated to 32 bits.
    function automatic logic [sip_pkg::PARAM_W-1:0] fixed_quot(longint num, longint den);
        longint q;
        longint lim;
        lim = 64'sd1 <<< 31;
        q = (num <<< sip_pkg::FRAC_BITS_DEF) / den;
        if (q > lim - 1) q = lim - 1;
        if (q < -lim) q = -lim;
        return q[sip_pkg::PARAM_W-1:0];
    endfunction

    function automatic isect_t predict_isect(coord_t c[8]);
        longint v[8];
        longint dpx, dpy, dqx, dqy, rx, ry, den;
        isect_t r;
        for (int i = 0; i < 8; i++) v[i] = longint'($signed(c[i]));
        dpx = v[2] - v[0];
        dpy = v[3] - v[1];
        dqx = v[6] - v[4];
        dqy = v[7] - v[5];
        rx  = v[0] - v[4];
        ry  = v[1] - v[5];
        den = dpx * dqy - dpy * dqx;
        if (den == 0) return '0;
        r.param_a    = fixed_quot(ry * dqx - rx * dqy, den);
        r.param_b    = fixed_quot(ry * dpx - rx * dpy, den);
        r.lines_meet = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [sip_pkg::PARAM_W-1:0] got,
                                   logic [sip_pkg::PARAM_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Response checking and the stall watchdog, at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected transaction", rsp.param_a, '0);
                else
                begin
                    isect_t e;
                    e = expected_q.pop_front();
                    if (rsp.param_a !== e.param_a)
                        report_mismatch("param_a", rsp.param_a, e.param_a);
                    if (rsp.param_b !== e.param_b)
                        report_mismatch("param_b", rsp.param_b, e.param_b);
                    if (rsp.lines_meet !== e.lines_meet)
                        report_mismatch("lines_meet",
                                        sip_pkg::PARAM_W'(rsp.lines_meet),
                                        sip_pkg::PARAM_W'(e.lines_meet));
                end
            end
        end
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("watchdog: no transaction for %0d cycles", WDOG_MAX);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(vec_t v);
        isect_t p;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        {req.p1_x, req.p1_y, req.p2_x, req.p2_y, req.q1_x, req.q1_y, req.q2_x, req.q2_y}
            <= {v.c[0], v.c[1], v.c[2], v.c[3], v.c[4], v.c[5], v.c[6], v.c[7]};
        p = predict_isect(v.c);
        if (v.has_exp && p !== v.exp)
            report_mismatch("predictor vs table",
                            p[2*sip_pkg::PARAM_W:sip_pkg::PARAM_W+1],
                            v.exp[2*sip_pkg::PARAM_W:sip_pkg::PARAM_W+1]);
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        expected_q.push_back(v.has_exp ? v.exp : p);
        @(negedge clk);
    endtask

    function automatic vec_t mk(int a0, int a1, int a2, int a3, int a4, int a5,
                                int a6, int a7, logic he, isect_t e);
        vec_t v;
        v.c[0] = coord_t'(a0); v.c[1] = coord_t'(a1);
        v.c[2] = coord_t'(a2); v.c[3] = coord_t'(a3);
        v.c[4] = coord_t'(a4); v.c[5] = coord_t'(a5);
        v.c[6] = coord_t'(a6); v.c[7] = coord_t'(a7);
        v.has_exp = he;
        v.exp = e;
        return v;
    endfunction

    // Random segment pair; the shape picks small, full-range, parallel or degenerate cases.
    function automatic vec_t rand_item();
        vec_t v;
        int shape;
        shape = $urandom_range(9);
        for (int i = 0; i < 8; i++)
            v.c[i] = (shape < 4) ? coord_t'($urandom_range(64) - 32) : coord_t'($urandom);
        if (shape == 8)
        begin
            // Second segment is the first one shifted, so the lines are parallel.
            int dx, dy;
            dx = $urandom_range(200) - 100;
            dy = $urandom_range(200) - 100;
            v.c[4] = v.c[0] + coord_t'(dx); v.c[5] = v.c[1] + coord_t'(dy);
            v.c[6] = v.c[2] + coord_t'(dx); v.c[7] = v.c[3] + coord_t'(dy);
        end
        else if (shape == 9)
        begin
            // Degenerate first segment.
            v.c[2] = v.c[0];
            v.c[3] = v.c[1];
        end
        v.has_exp = 1'b0;
        v.exp = '0;
        return v;
    endfunction

    initial
    begin
        vec_t   table_q[$];
        isect_t z, half, one_b;
        z = '0;
        half  = '{param_a: 32'h0000_8000, param_b: 32'h0000_8000, lines_meet: 1'b1};
        one_b = '{param_a: 32'h0000_0000, param_b: 32'h0000_8000, lines_meet: 1'b1};

        req.valid <= 1'b0;
        {req.p1_x, req.p1_y, req.p2_x, req.p2_y, req.q1_x, req.q1_y, req.q2_x, req.q2_y} <= '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: all zero, crossing diagonals, parallel, degenerate, extremes.
        table_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, z));
        table_q.push_back(mk(0, 0, 2, 2, 0, 2, 2, 0, 1, half));
        table_q.push_back(mk(0, 0, 4, 0, 4, -3, 4, 5, 1, '{32'h0001_0000, 32'h0000_6000, 1'b1}));
        table_q.push_back(mk(0, 0, 5, 5, 1, 0, 6, 5, 1, z));
        table_q.push_back(mk(3, 3, 3, 3, 0, 0, 9, 1, 1, z));
        table_q.push_back(mk(0, 0, 1, 0, 0, -1, 0, 1, 1, '{32'h0, 32'h0000_8000, 1'b1}));
        table_q.push_back(mk(0, 0, 1, 0, 40000, -1, 40000, 1, 0, z));
        table_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0, z));
        table_q.push_back(mk(-32768, 0, -32767, 0, 32767, -1, 32767, 0, 0, z));
        table_q.push_back(mk(32767, 0, 32766, 0, -32768, 0, -32768, 1, 0, z));
        table_q.push_back(mk(-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767,
                             0, z));
        table_q.push_back(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767,
                             0, z));
        table_q.push_back(mk(0, 0, 0, 1, -5, 0, 5, 0, 1, one_b));
        table_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, 1, z));
        table_q.push_back(mk(0, 0, 1, 1, 0, 1, 1, 2, 1, z));
        foreach (table_q[i]) send_item(table_q[i]);

        // Random part in three idling phases.
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 74 : 0;
            snk_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 15 : 0;
            for (int i = 0; i < N_RANDOM / 3; i++) send_item(rand_item());
        end
        req.valid <= 1'b0;

        while (expected_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
